// ----- sv/cbd_pkg.sv -----
// Package for the chunked body decoder: phase and number-parse codes,
// result kinds, byte constants and character-class helpers.
// Depends on nothing; the parser, the top level and the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 63;
  localparam int unsigned SIZE_BITS_DEF  = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_LINE = 3'd0,
    PH_DATA = 3'd1,
    PH_TCR  = 3'd2,
    PH_TLF  = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    DS_START  = 3'd0,
    DS_ZERO   = 3'd1,
    DS_XSEEN  = 3'd2,
    DS_DIGITS = 3'd3,
    DS_OK     = 3'd4,
    DS_FAIL   = 3'd5
  } digit_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    kind_e      kind;
    logic       chunk_last;
  } result_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_dec(c) || is_lower(c) || is_upper(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Only meaningful when is_hex() holds.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (is_dec(c)) begin
      v = c - 8'h30;
    end else if (is_lower(c)) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/cbd_if.sv -----
// Valid/ready channel interfaces of the chunked body decoder: one for the
// incoming byte stream and one for the decoded results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] kind;
  logic       chunk_last;

  modport source (output valid, output payload_byte, output kind, output chunk_last,
                  input ready);
  modport sink   (input valid, input payload_byte, input kind, input chunk_last,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/cbd_parser.sv -----
// Per-byte parser of the chunked body decoder: holds the decode state and
// works out the result and next state of one byte combinationally.
// Depends on cbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbd_parser
  import cbd_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       action_i,
  input  wire logic [7:0] byte_i,
  output      logic       emit_o,
  output      result_t    result_o
);

  localparam int unsigned LcW = $clog2(LINE_LIMIT);

  phase_e                 phase_q, phase_d;
  digit_e                 digit_q, digit_d;
  logic [LcW-1:0]         count_q, count_d;
  logic                   prev_cr_q, prev_cr_d;
  logic [SIZE_BITS-1:0]   size_q, size_d;
  logic [SIZE_BITS-1:0]   left_q, left_d;

  logic                   cr_ok, lf_end, alnum, hex, count_hit, sat;
  logic [3:0]             hval;
  logic [SIZE_BITS-1:0]   acc;

  assign cr_ok     = (byte_i == CH_CR) && (count_q != '0) && !prev_cr_q;
  assign lf_end    = (byte_i == CH_LF) && prev_cr_q;
  assign alnum     = is_alnum(byte_i);
  assign hex       = is_hex(byte_i);
  assign hval      = hex_val(byte_i);
  assign count_hit = (count_q == LcW'(LINE_LIMIT - 1));

  // Appending a digit overflows exactly when the top nibble is already non-zero.
  assign sat = |size_q[SIZE_BITS-1 -: 4];
  assign acc = sat ? '1 : {size_q[SIZE_BITS-5:0], hval};

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    digit_d   = digit_q;
    count_d   = count_q;
    prev_cr_d = prev_cr_q;
    size_d    = size_q;
    left_d    = left_q;
    if (action_i) begin
      phase_d   = PH_LINE;
      digit_d   = DS_START;
      count_d   = '0;
      prev_cr_d = 1'b0;
      size_d    = '0;
      left_d    = '0;
    end else begin
      unique case (phase_q)
        PH_LINE: begin
          if (cr_ok) begin
            if (digit_q == DS_ZERO || digit_q == DS_DIGITS) begin
              digit_d = DS_OK;
            end else if (digit_q != DS_OK) begin
              digit_d = DS_FAIL;
            end
            prev_cr_d = 1'b1;
            count_d   = count_q + 1'b1;
            if (count_hit) phase_d = PH_DONE;
          end else if (lf_end) begin
            if (digit_q != DS_OK || size_q == '0) begin
              phase_d = PH_DONE;
            end else begin
              left_d    = size_q;
              phase_d   = PH_DATA;
              digit_d   = DS_START;
              count_d   = '0;
              prev_cr_d = 1'b0;
              size_d    = '0;
            end
          end else if (!alnum) begin
            phase_d = PH_DONE;
          end else begin
            unique case (digit_q)
              DS_START: begin
                if (!hex) begin
                  digit_d = DS_FAIL;
                end else begin
                  size_d  = SIZE_BITS'(hval);
                  digit_d = (byte_i == 8'h30) ? DS_ZERO : DS_DIGITS;
                end
              end
              DS_ZERO: begin
                if (hex) begin
                  size_d  = acc;
                  digit_d = DS_DIGITS;
                end else if (byte_i == 8'h78 || byte_i == 8'h58) begin
                  digit_d = DS_XSEEN;
                end else begin
                  digit_d = DS_FAIL;
                end
              end
              DS_XSEEN, DS_DIGITS: begin
                if (hex) begin
                  size_d  = acc;
                  digit_d = DS_DIGITS;
                end else begin
                  digit_d = DS_FAIL;
                end
              end
              default: ;
            endcase
            prev_cr_d = 1'b0;
            count_d   = count_q + 1'b1;
            if (count_hit) phase_d = PH_DONE;
          end
        end
        PH_DATA: begin
          left_d = left_q - 1'b1;
          if (left_q == SIZE_BITS'(1)) phase_d = PH_TCR;
        end
        PH_TCR:  phase_d = (byte_i == CH_CR) ? PH_TLF : PH_DONE;
        PH_TLF: begin
          if (byte_i == CH_LF) begin
            phase_d   = PH_LINE;
            digit_d   = DS_START;
            count_d   = '0;
            prev_cr_d = 1'b0;
            size_d    = '0;
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the current byte.
  always_comb begin
    emit_o                = 1'b0;
    result_o.payload_byte = 8'h00;
    result_o.kind         = KIND_ERR;
    result_o.chunk_last   = 1'b0;
    if (!action_i) begin
      unique case (phase_q)
        PH_LINE: begin
          if (cr_ok) begin
            emit_o = count_hit;
          end else if (lf_end) begin
            if (digit_q != DS_OK) begin
              emit_o = 1'b1;
            end else if (size_q == '0) begin
              emit_o        = 1'b1;
              result_o.kind = KIND_END;
            end
          end else if (!alnum) begin
            emit_o = 1'b1;
          end else begin
            emit_o = count_hit;
          end
        end
        PH_DATA: begin
          emit_o                = 1'b1;
          result_o.kind         = KIND_DATA;
          result_o.payload_byte = byte_i;
          result_o.chunk_last   = (left_q == SIZE_BITS'(1));
        end
        PH_TCR:  emit_o = (byte_i != CH_CR);
        PH_TLF:  emit_o = (byte_i != CH_LF);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LINE;
      digit_q   <= DS_START;
      count_q   <= '0;
      prev_cr_q <= 1'b0;
      size_q    <= '0;
      left_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      digit_q   <= digit_d;
      count_q   <= count_d;
      prev_cr_q <= prev_cr_d;
      size_q    <= size_d;
      left_q    <= left_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/chunked_body_decoder_top.sv -----
// Chunked body decoder, top level: input register, per-byte parser and
// result register with valid/ready handshakes on both sides.
// Depends on cbd_pkg, cbd_if and cbd_parser.
//
// Usage:
//   in_i carries one transaction per received byte (action = 0) or a start
//   command (action = 1) that returns the decoder to the start of a new body.
//   out_o carries decoded payload bytes (kind 0, chunk_last on the last byte
//   of each chunk), one end-of-body result (kind 1) or one protocol error
//   (kind 2). After an end or an error all bytes are dropped until a start.
//   Path: an accepted transaction waits in the input register; when it is
//   parsed, its result is captured in the result register and presented
//   on out_o from then on.
//   Throughput: one byte per cycle while no stall holds the input register;
//   the parser's state update lies between the input and result registers.
//   Stalls: a result waiting on out_o does not block the byte in the input
//   register unless that byte also produces a result; in that case the input
//   register holds and in_i.ready drops until out_o.ready frees the slot.
//   Reset: rst_ni is asynchronous and active low; it empties both registers
//   and puts the parser at the start of a size line, as after a start.
`timescale 1ns / 1ps
`default_nettype none

module chunked_body_decoder_top
  import cbd_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cbd_in_if.sink     in_i,
  cbd_out_if.source  out_o
);

  logic       in_valid_q, in_valid_d;
  logic       in_action_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;

  logic       in_take, out_free, step, emit;
  result_t    result;

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && (!emit || out_free);
  assign in_i.ready = !in_valid_q || step;
  assign in_take    = in_i.valid && in_i.ready;

  cbd_parser #(
    .LINE_LIMIT (LINE_LIMIT),
    .SIZE_BITS  (SIZE_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .action_i (in_action_q),
    .byte_i   (in_byte_q),
    .emit_o   (emit),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= in_i.action;
      in_byte_q   <= in_i.in_byte;
    end
    if (step && emit) begin
      out_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.payload_byte = out_q.payload_byte;
  assign out_o.kind         = out_q.kind;
  assign out_o.chunk_last   = out_q.chunk_last;

endmodule

`default_nettype wire

// ----- sv/cbd_checker.sv -----
// Port-level checker for the chunked body decoder, bound to the top level.
// Depends on cbd_pkg and chunked_body_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module cbd_checker
  import cbd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] payload_byte_i,
  input wire logic [1:0] kind_i,
  input wire logic       chunk_last_i
);

  // A result once offered stays offered until the transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == KIND_DATA || kind_i == KIND_END || kind_i == KIND_ERR))
    else $error("unknown result kind");

  a_last_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && chunk_last_i |-> kind_i == KIND_DATA)
    else $error("chunk_last on a non-payload result");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KIND_DATA |-> payload_byte_i == 8'h00)
    else $error("end or error result carries a payload byte");

endmodule

bind chunked_body_decoder_top cbd_checker u_cbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .payload_byte_i (out_o.payload_byte),
  .kind_i         (out_o.kind),
  .chunk_last_i   (out_o.chunk_last)
);

`default_nettype wire
